// ----- design/cll_pkg.sv -----
// shared constants, codes and control types of the cursor linked list engine
package cll_pkg;

  localparam int NODES  = 1024;
  localparam int POS_W  = $clog2(NODES);
  localparam int CNT_W  = POS_W + 1;
  localparam int ELEM_W = 32;
  localparam int ACT_W  = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_NEW    = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_PREV   = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_READ   = 3'd6,
    ACT_INIT   = 3'd7
  } action_e;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC_CHK,
    ST_ALLOC_WR0,
    ST_NEW_WR,
    ST_INS_ELEM,
    ST_INS_WRN,
    ST_INS_WRPOS,
    ST_WALK_A,
    ST_WALK_B,
    ST_DEL_UNLINK,
    ST_FREE_RD0,
    ST_FREE_WRN,
    ST_FREE_WR0,
    ST_CLR_HEAD,
    ST_CLR_A,
    ST_CLR_B,
    ST_RPT,
    ST_FIN_NODE,
    ST_FIN_NONE,
    ST_INIT
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_LINK,
    OP_WR_LINK,
    OP_TAKE,
    OP_INS,
    OP_WALK,
    OP_STEP,
    OP_CLR_HEAD,
    OP_CLR_NEXT,
    OP_CLR_SAVE,
    OP_FREE_LINK0,
    OP_RPT,
    OP_SWEEP,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [2:0] {
    AS_ZERO,
    AS_HEAD,
    AS_POS,
    AS_N,
    AS_P,
    AS_RDATA
  } addr_sel_e;

  typedef enum logic [1:0] {
    LD_ZERO,
    LD_RDATA,
    LD_N
  } link_dat_e;

  typedef struct packed {
    dp_op_e    op;
    addr_sel_e sel;
    link_dat_e dat;
    logic      node;
    logic      found;
    logic      status;
  } dp_cmd_t;

  typedef struct packed {
    action_e act;
    logic    rdata_zero;
    logic    n_zero;
    logic    match;
    logic    walk_end;
    logic    sweep_last;
    logic    out_free;
  } dp_status_t;

endpackage

// ----- design/cll_if.sv -----
// valid/ready channels for command items and result items
interface cll_in_if import cll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [POS_W-1:0]  list_head;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element;

  modport source (output valid, action, list_head, position, element, input ready);
  modport sink   (input valid, action, list_head, position, element, output ready);
endinterface

interface cll_out_if import cll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  result_position;
  logic [ELEM_W-1:0] result_element;
  logic [POS_W-1:0]  next_position;
  logic              is_last;
  logic              found;
  logic              status;

  modport source (output valid, result_position, result_element, next_position, is_last,
                  found, status, input ready);
  modport sink   (input valid, result_position, result_element, next_position, is_last,
                  found, status, output ready);
endinterface

// ----- design/cll_datapath.sv -----
// node stores, walk registers and result register of the linked list engine
module cll_datapath import cll_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [POS_W-1:0]  list_head_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [ELEM_W-1:0] element_i,
  cll_out_if.source         out_o
);

  logic [ELEM_W-1:0] elem_mem [NODES];
  logic [POS_W-1:0]  link_mem [NODES];

  action_e           act_q;
  logic [POS_W-1:0]  head_q, pos_q, n_q, p_q, res_q;
  logic [ELEM_W-1:0] x_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  link_rd_q;
  logic [ELEM_W-1:0] elem_rd_q;

  logic              out_valid_q;
  logic [POS_W-1:0]  out_pos_q, out_next_q;
  logic [ELEM_W-1:0] out_elem_q;
  logic              out_last_q, out_found_q, out_status_q;

  logic [POS_W-1:0]  addr;
  logic [POS_W-1:0]  wdata;
  logic [POS_W-1:0]  sweep_idx;
  logic [POS_W-1:0]  sweep_link;
  logic              link_we, link_re, elem_re, elem_we;
  logic [POS_W-1:0]  link_waddr, link_wdata;
  logic              out_free;

  assign sweep_idx  = cnt_q[POS_W-1:0];
  assign sweep_link = (cnt_q == CNT_W'(NODES - 1)) ? '0 : sweep_idx + 1'b1;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    unique case (cmd_i.sel)
      AS_ZERO:  addr = '0;
      AS_HEAD:  addr = head_q;
      AS_POS:   addr = pos_q;
      AS_N:     addr = n_q;
      AS_P:     addr = p_q;
      AS_RDATA: addr = link_rd_q;
      default:  addr = '0;
    endcase
    unique case (cmd_i.dat)
      LD_ZERO:  wdata = '0;
      LD_RDATA: wdata = link_rd_q;
      LD_N:     wdata = n_q;
      default:  wdata = '0;
    endcase
  end

  always_comb begin
    link_re    = 1'b0;
    elem_re    = 1'b0;
    link_we    = 1'b0;
    elem_we    = 1'b0;
    link_waddr = addr;
    link_wdata = wdata;
    unique case (cmd_i.op)
      OP_RD_LINK, OP_TAKE, OP_CLR_NEXT, OP_CLR_SAVE: link_re = 1'b1;
      OP_INS: begin
        link_re = 1'b1;
        elem_we = 1'b1;
      end
      OP_WALK, OP_RPT: begin
        link_re = 1'b1;
        elem_re = 1'b1;
      end
      OP_WR_LINK, OP_CLR_HEAD, OP_FREE_LINK0: link_we = 1'b1;
      OP_SWEEP: begin
        link_we    = 1'b1;
        link_waddr = sweep_idx;
        link_wdata = sweep_link;
      end
      default: ;
    endcase
  end

  // single port link store: one access per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[n_q] <= x_q;
    end
    if (elem_re) begin
      elem_rd_q <= elem_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.op == OP_LOAD) begin
      cnt_q <= '0;
    end else if (cmd_i.op == OP_WALK || cmd_i.op == OP_CLR_NEXT || cmd_i.op == OP_SWEEP) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        act_q  <= action_e'(action_i);
        head_q <= list_head_i;
        pos_q  <= position_i;
        x_q    <= element_i;
        p_q    <= list_head_i;
      end
      OP_TAKE, OP_WALK, OP_CLR_HEAD: n_q <= link_rd_q;
      OP_STEP:       p_q   <= n_q;
      OP_CLR_SAVE:   p_q   <= link_rd_q;
      OP_FREE_LINK0: n_q   <= p_q;
      OP_RPT:        res_q <= addr;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      out_found_q  <= cmd_i.found;
      out_status_q <= cmd_i.status;
      if (cmd_i.node) begin
        out_pos_q  <= res_q;
        out_elem_q <= elem_rd_q;
        out_next_q <= link_rd_q;
        out_last_q <= (link_rd_q == '0);
      end else begin
        out_pos_q  <= '0;
        out_elem_q <= '0;
        out_next_q <= '0;
        out_last_q <= 1'b0;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.result_position = out_pos_q;
  assign out_o.result_element  = out_elem_q;
  assign out_o.next_position   = out_next_q;
  assign out_o.is_last         = out_last_q;
  assign out_o.found           = out_found_q;
  assign out_o.status          = out_status_q;

  assign status_o.act        = act_q;
  assign status_o.rdata_zero = (link_rd_q == '0);
  assign status_o.n_zero     = (n_q == '0);
  assign status_o.match      = (elem_rd_q == x_q);
  assign status_o.walk_end   = (cnt_q == CNT_W'(NODES));
  assign status_o.sweep_last = (cnt_q == CNT_W'(NODES - 1));
  assign status_o.out_free   = out_free;

endmodule

// ----- design/cll_ctrl.sv -----
// sequencer that steps the datapath through each list action
module cll_ctrl import cll_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;
  logic       act_search;
  logic       act_alloc;
  addr_sel_e  rpt_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign act_search = (status_i.act == ACT_DELETE) || (status_i.act == ACT_FIND) ||
                      (status_i.act == ACT_PREV);
  assign act_alloc  = (status_i.act == ACT_NEW) || (status_i.act == ACT_INSERT);

  always_comb begin
    unique case (status_i.act)
      ACT_DELETE, ACT_PREV: rpt_sel = AS_P;
      ACT_CLEAR:            rpt_sel = AS_HEAD;
      ACT_READ:             rpt_sel = AS_POS;
      default:              rpt_sel = AS_N;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NOP, sel: AS_ZERO, dat: LD_ZERO, node: 1'b0, found: 1'b0,
                   status: 1'b0};
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.act)
          ACT_NEW, ACT_INSERT: begin
            cmd_o.op  = OP_RD_LINK;
            cmd_o.sel = AS_ZERO;
            state_d   = ST_ALLOC_CHK;
          end
          ACT_DELETE, ACT_FIND, ACT_PREV: begin
            cmd_o.op  = OP_RD_LINK;
            cmd_o.sel = AS_HEAD;
            state_d   = ST_WALK_A;
          end
          ACT_CLEAR: begin
            cmd_o.op  = OP_RD_LINK;
            cmd_o.sel = AS_HEAD;
            state_d   = ST_CLR_HEAD;
          end
          ACT_READ: state_d = ST_RPT;
          ACT_INIT: state_d = ST_INIT;
          default:  state_d = ST_FIN_NONE;
        endcase
      end
      ST_ALLOC_CHK: begin
        // head of the free chain is zero: nothing left to hand out
        if (status_i.rdata_zero) begin
          state_d = ST_FIN_NONE;
        end else begin
          cmd_o.op  = OP_TAKE;
          cmd_o.sel = AS_RDATA;
          state_d   = ST_ALLOC_WR0;
        end
      end
      ST_ALLOC_WR0: begin
        cmd_o.op  = OP_WR_LINK;
        cmd_o.sel = AS_ZERO;
        cmd_o.dat = LD_RDATA;
        state_d   = (status_i.act == ACT_NEW) ? ST_NEW_WR : ST_INS_ELEM;
      end
      ST_NEW_WR: begin
        cmd_o.op  = OP_WR_LINK;
        cmd_o.sel = AS_N;
        cmd_o.dat = LD_ZERO;
        state_d   = ST_RPT;
      end
      ST_INS_ELEM: begin
        cmd_o.op  = OP_INS;
        cmd_o.sel = AS_POS;
        state_d   = ST_INS_WRN;
      end
      ST_INS_WRN: begin
        cmd_o.op  = OP_WR_LINK;
        cmd_o.sel = AS_N;
        cmd_o.dat = LD_RDATA;
        state_d   = ST_INS_WRPOS;
      end
      ST_INS_WRPOS: begin
        cmd_o.op  = OP_WR_LINK;
        cmd_o.sel = AS_POS;
        cmd_o.dat = LD_N;
        state_d   = ST_RPT;
      end
      ST_WALK_A: begin
        if (status_i.walk_end || status_i.rdata_zero) begin
          state_d = ST_FIN_NONE;
        end else begin
          cmd_o.op  = OP_WALK;
          cmd_o.sel = AS_RDATA;
          state_d   = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        if (status_i.match) begin
          state_d = (status_i.act == ACT_DELETE) ? ST_DEL_UNLINK : ST_RPT;
        end else begin
          cmd_o.op = OP_STEP;
          state_d  = ST_WALK_A;
        end
      end
      ST_DEL_UNLINK: begin
        // read data still holds the link of the matching node
        cmd_o.op  = OP_WR_LINK;
        cmd_o.sel = AS_P;
        cmd_o.dat = LD_RDATA;
        state_d   = ST_FREE_RD0;
      end
      ST_FREE_RD0: begin
        cmd_o.op  = OP_RD_LINK;
        cmd_o.sel = AS_ZERO;
        state_d   = ST_FREE_WRN;
      end
      ST_FREE_WRN: begin
        cmd_o.op  = OP_WR_LINK;
        cmd_o.sel = AS_N;
        cmd_o.dat = LD_RDATA;
        state_d   = ST_FREE_WR0;
      end
      ST_FREE_WR0: begin
        cmd_o.op  = OP_FREE_LINK0;
        cmd_o.sel = AS_ZERO;
        cmd_o.dat = LD_N;
        state_d   = (status_i.act == ACT_DELETE) ? ST_RPT : ST_CLR_A;
      end
      ST_CLR_HEAD: begin
        cmd_o.op  = OP_CLR_HEAD;
        cmd_o.sel = AS_HEAD;
        cmd_o.dat = LD_ZERO;
        state_d   = ST_CLR_A;
      end
      ST_CLR_A: begin
        if (status_i.n_zero || status_i.walk_end) begin
          state_d = ST_RPT;
        end else begin
          cmd_o.op  = OP_CLR_NEXT;
          cmd_o.sel = AS_N;
          state_d   = ST_CLR_B;
        end
      end
      ST_CLR_B: begin
        // keep the successor, then fetch the free chain head
        cmd_o.op  = OP_CLR_SAVE;
        cmd_o.sel = AS_ZERO;
        state_d   = ST_FREE_WRN;
      end
      ST_RPT: begin
        cmd_o.op  = OP_RPT;
        cmd_o.sel = rpt_sel;
        state_d   = ST_FIN_NODE;
      end
      ST_FIN_NODE: begin
        if (status_i.out_free) begin
          cmd_o.op    = OP_FINISH;
          cmd_o.node  = 1'b1;
          cmd_o.found = act_search;
          state_d     = ST_IDLE;
        end
      end
      ST_FIN_NONE: begin
        if (status_i.out_free) begin
          cmd_o.op     = OP_FINISH;
          cmd_o.status = act_alloc;
          state_d      = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd_o.op = OP_SWEEP;
        if (status_i.sweep_last) begin
          state_d = ST_FIN_NONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- design/cursor_linked_list_engine.sv -----
// top level of the cursor linked list engine with free chain
// One action is in flight at a time; a new transaction is taken once the
// previous one has reached the result register, which holds it until the
// sink takes it. The single-port link store allows one link access per
// cycle. A walk gives up after NODES links. After reset the link store is
// rebuilt by a pass over all NODES entries before the first transaction
// is taken; element contents are undefined until written and must not be
// read before that.
module cursor_linked_list_engine import cll_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cll_in_if.sink    in_i,
  cll_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  cll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  cll_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .action_i    (in_i.action),
    .list_head_i (in_i.list_head),
    .position_i  (in_i.position),
    .element_i   (in_i.element),
    .out_o       (out_o)
  );

endmodule

// ----- design/cll_checker.sv -----
// port level assertions for the cursor linked list engine, bound to the top
module cll_checker import cll_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [POS_W-1:0] result_position_i,
  input logic [POS_W-1:0] next_position_i,
  input logic             is_last_i,
  input logic             found_i,
  input logic             status_i
);

  // one transaction at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while a transaction is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // out of space reports no node and no match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i) |-> (result_position_i == '0) && !found_i && !is_last_i)
    else $error("out of space result carries a node");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_last_i) |-> (next_position_i == '0))
    else $error("last node flagged with a nonzero next link");

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .result_position_i (out_o.result_position),
  .next_position_i   (out_o.next_position),
  .is_last_i         (out_o.is_last),
  .found_i           (out_o.found),
  .status_i          (out_o.status)
);
